FILE: sv/poisson_binomial_tail_counter_macros.svh
// ----------------------------------------------------------------------------
// Poisson-binomial tail counter assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef POISSON_BINOMIAL_TAIL_COUNTER_MACROS_SVH
`define POISSON_BINOMIAL_TAIL_COUNTER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PBTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PBTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pbtc_pkg.sv
// ----------------------------------------------------------------------------
// pbtc_pkg
// Types and constants shared by the tail counter and its bucket cells.
// ----------------------------------------------------------------------------
package pbtc_pkg;

  localparam int PROB_W = 17;
  localparam int BKT_W  = 6;
  localparam int PROD_W = 2 * PROB_W;

  localparam logic [PROB_W-1:0] ONE_Q16       = 17'h10000;
  localparam logic [BKT_W-1:0]  THRESHOLD_RST = 6'd8;

  typedef struct packed {
    logic [PROB_W-1:0] prob_a;
    logic [PROB_W-1:0] prob_b;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [BKT_W-1:0]  bucket;
    logic [PROB_W-1:0] probability;
    logic              final_res;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UPDATE,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PROB_W-1:0] p;
    logic [PROB_W-1:0] q;
    logic [BKT_W-1:0]  thr;
  } cell_ctrl_t;

endpackage

FILE: sv/pbtc_cell.sv
// ----------------------------------------------------------------------------
// pbtc_cell
// One count bucket: applies an event using its left neighbor, or shifts
// the value of its right neighbor in during readout, or clears to its reset value.
// ----------------------------------------------------------------------------
module pbtc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pbtc_pkg::cell_ctrl_t             ctrl,
  input  logic [pbtc_pkg::PROB_W-1:0]      left_val,
  input  logic [pbtc_pkg::PROB_W-1:0]      right_val,
  output logic [pbtc_pkg::PROB_W-1:0]      val
);

  localparam logic [pbtc_pkg::PROB_W-1:0] RST_VAL =
    (CELL_IDX == 0) ? pbtc_pkg::ONE_Q16 : '0;
  localparam logic [pbtc_pkg::BKT_W-1:0] IDX = pbtc_pkg::BKT_W'(CELL_IDX);

  logic [pbtc_pkg::PROB_W-1:0] val_r, val_nxt;
  logic [pbtc_pkg::PROD_W-1:0] mul_in, mul_own;
  logic [pbtc_pkg::PROB_W:0]   prod_in, prod_own;
  logic [pbtc_pkg::PROB_W+1:0] sum;
  logic [pbtc_pkg::PROB_W-1:0] upd;

  assign mul_in   = pbtc_pkg::PROD_W'(ctrl.p) * pbtc_pkg::PROD_W'(left_val);
  assign mul_own  = pbtc_pkg::PROD_W'(ctrl.q) * pbtc_pkg::PROD_W'(val_r);
  assign prod_in  = mul_in[pbtc_pkg::PROD_W-1:16];
  assign prod_own = mul_own[pbtc_pkg::PROD_W-1:16];

  always_comb begin
    if (IDX == ctrl.thr) begin
      sum = (pbtc_pkg::PROB_W+2)'(val_r) + (pbtc_pkg::PROB_W+2)'(prod_in);
    end else begin
      sum = (pbtc_pkg::PROB_W+2)'(prod_in) + (pbtc_pkg::PROB_W+2)'(prod_own);
    end
    if (sum > (pbtc_pkg::PROB_W+2)'(pbtc_pkg::ONE_Q16)) begin
      upd = pbtc_pkg::ONE_Q16;
    end else begin
      upd = sum[pbtc_pkg::PROB_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.op)
      pbtc_pkg::CELL_UPDATE: val_nxt = (IDX > ctrl.thr) ? val_r : upd;
      pbtc_pkg::CELL_SHIFT:  val_nxt = right_val;
      pbtc_pkg::CELL_CLEAR:  val_nxt = RST_VAL;
      default:               val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= RST_VAL;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

FILE: sv/poisson_binomial_tail_counter.sv
// ----------------------------------------------------------------------------
// poisson_binomial_tail_counter
// Count distribution of independent events, one bucket cell per count.
// Throughput: one item per cycle when in_ready; the event probability is
//   formed in one register stage, the cell row updates in the next.
// A last item: past the first stage, readout emits effective threshold+1
//   results, one per out_ready cycle; input held off until top bucket transfers.
// Reset (rst_n, synchronous): bucket 0 = 1.0, others 0, threshold = 8.
// ----------------------------------------------------------------------------
module poisson_binomial_tail_counter #(
  parameter int MAX_THRESHOLD = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pbtc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pbtc_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [pbtc_pkg::BKT_W-1:0]    cfg_wdata
);

  localparam int NCELL = MAX_THRESHOLD + 1;
  localparam logic [pbtc_pkg::BKT_W-1:0] MAX_T = pbtc_pkg::BKT_W'(MAX_THRESHOLD);
  localparam int PW = pbtc_pkg::PROB_W;

  typedef enum logic {ST_RUN, ST_EMIT} state_t;

  state_t                     state_r;
  logic [pbtc_pkg::BKT_W-1:0] thr_r;
  logic                       s1_vld_r, s1_last_r;
  logic [PW-1:0]              s1_p_r, s1_q_r;
  logic [pbtc_pkg::BKT_W-1:0] s1_t_r;
  logic [pbtc_pkg::BKT_W-1:0] emit_cnt_r, emit_t_r;

  logic [PW-1:0]              a_sat, b_sat, p_nxt;
  logic [pbtc_pkg::PROD_W-1:0] ab;
  logic [PW:0]                or_sum;
  logic [pbtc_pkg::BKT_W-1:0] t_eff;
  logic                       in_xfer, out_xfer, is_final;
  pbtc_pkg::cell_ctrl_t       ctrl;
  logic [PW-1:0]              cell_val [NCELL];

  // probabilistic OR of the two inputs, and the clamped threshold
  always_comb begin
    a_sat  = (in_data.prob_a > pbtc_pkg::ONE_Q16) ? pbtc_pkg::ONE_Q16 : in_data.prob_a;
    b_sat  = (in_data.prob_b > pbtc_pkg::ONE_Q16) ? pbtc_pkg::ONE_Q16 : in_data.prob_b;
    ab     = pbtc_pkg::PROD_W'(a_sat) * pbtc_pkg::PROD_W'(b_sat);
    or_sum = (PW+1)'(a_sat) + (PW+1)'(b_sat) - ab[pbtc_pkg::PROD_W-1:16];
    p_nxt  = (or_sum > (PW+1)'(pbtc_pkg::ONE_Q16)) ? pbtc_pkg::ONE_Q16 : or_sum[PW-1:0];
    if (thr_r == '0) begin
      t_eff = pbtc_pkg::BKT_W'(1);
    end else if (thr_r > MAX_T) begin
      t_eff = MAX_T;
    end else begin
      t_eff = thr_r;
    end
  end

  assign in_ready  = (state_r == ST_RUN) && !(s1_vld_r && s1_last_r);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (state_r == ST_EMIT);
  assign out_xfer  = out_valid && out_ready;
  assign is_final  = (emit_cnt_r == emit_t_r);

  assign out_data.bucket      = emit_cnt_r;
  assign out_data.probability = cell_val[0];
  assign out_data.final_res   = is_final;

  always_comb begin
    ctrl.p   = s1_p_r;
    ctrl.q   = s1_q_r;
    ctrl.thr = s1_t_r;
    if (state_r == ST_EMIT) begin
      if (out_xfer) begin
        ctrl.op = is_final ? pbtc_pkg::CELL_CLEAR : pbtc_pkg::CELL_SHIFT;
      end else begin
        ctrl.op = pbtc_pkg::CELL_HOLD;
      end
    end else if (s1_vld_r && (s1_p_r != '0)) begin
      ctrl.op = pbtc_pkg::CELL_UPDATE;
    end else begin
      ctrl.op = pbtc_pkg::CELL_HOLD;
    end
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic [PW-1:0] left_v, right_v;
    if (g == 0) begin : g_lo
      assign left_v = '0;
    end else begin : g_lo
      assign left_v = cell_val[g-1];
    end
    if (g == NCELL - 1) begin : g_hi
      assign right_v = '0;
    end else begin : g_hi
      assign right_v = cell_val[g+1];
    end
    pbtc_cell #(.CELL_IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      thr_r      <= pbtc_pkg::THRESHOLD_RST;
      s1_vld_r   <= 1'b0;
      s1_last_r  <= 1'b0;
      emit_cnt_r <= '0;
      emit_t_r   <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      s1_vld_r <= in_xfer;
      if (in_xfer) begin
        s1_last_r <= in_data.last;
        s1_t_r    <= t_eff;
      end
      case (state_r)
        ST_RUN: begin
          if (s1_vld_r && s1_last_r) begin
            state_r    <= ST_EMIT;
            emit_cnt_r <= '0;
            emit_t_r   <= s1_t_r;
            s1_last_r  <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            if (is_final) begin
              state_r    <= ST_RUN;
              emit_cnt_r <= '0;
            end else begin
              emit_cnt_r <= emit_cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  // payload stage, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_p_r <= p_nxt;
      s1_q_r <= pbtc_pkg::ONE_Q16 - p_nxt;
    end
  end

endmodule

FILE: sv/pbtc_checker.sv
// ----------------------------------------------------------------------------
// pbtc_checker
// Port-level checks on the readout sequence of the tail counter.
// ----------------------------------------------------------------------------
`include "poisson_binomial_tail_counter_macros.svh"

module pbtc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pbtc_pkg::out_item_t out_data
);

  `PBTC_ASSERT_NOW(a_no_input_in_readout, out_valid, !in_ready, "input taken during readout")

  `PBTC_ASSERT_NOW(a_readout_starts_at_zero, $rose(out_valid), out_data.bucket == '0, "readout did not start at bucket 0")

  `PBTC_ASSERT_NEXT(a_readout_continues, out_valid && out_ready && !out_data.final_res, out_valid && (out_data.bucket == $past(out_data.bucket) + 1'b1), "readout broken before top bucket")

  `PBTC_ASSERT_NEXT(a_readout_ends, out_valid && out_ready && out_data.final_res, !out_valid, "result after top bucket")

endmodule

bind poisson_binomial_tail_counter pbtc_checker u_pbtc_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// poisson_binomial_tail_counter testbench
// Streams event probabilities into the tail counter and rebuilds the count
// distribution on the side in Q1.16. Every bucket emitted at the end of a
// vector is checked against the rebuilt one. Covers probability extremes,
// threshold range and mid-vector threshold changes, then random vectors under
// several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_THR      = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RUN_ITEMS    = 54;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  pbtc_pkg::in_item_t            in_data;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  pbtc_pkg::out_item_t           out_data;
  logic                          cfg_we;
  logic [pbtc_pkg::BKT_W-1:0]    cfg_wdata;

  logic [pbtc_pkg::PROB_W-1:0]   model_bins [0:MAX_THR];
  logic [pbtc_pkg::BKT_W-1:0]    model_threshold;
  pbtc_pkg::out_item_t           expected_bins [$];
  pbtc_pkg::out_item_t           next_bin;
  int                            fail_count = 0;
  int                            cycle_count;
  int                            send_idle_pct = 0;
  int                            recv_stall_pct = 0;

  poisson_binomial_tail_counter #(
    .MAX_THRESHOLD(MAX_THR)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // distribution predictor
  // ------------------------------------------------------------------------
  function automatic logic [pbtc_pkg::PROB_W-1:0] clamp_prob(input logic [63:0] v);
    return (v > 64'(pbtc_pkg::ONE_Q16)) ? pbtc_pkg::ONE_Q16 : v[pbtc_pkg::PROB_W-1:0];
  endfunction

  function automatic logic [pbtc_pkg::PROB_W-1:0] q16_mul(
    input logic [pbtc_pkg::PROB_W-1:0] x,
    input logic [pbtc_pkg::PROB_W-1:0] y);
    logic [pbtc_pkg::PROD_W-1:0] prod;
    prod = pbtc_pkg::PROD_W'(x) * pbtc_pkg::PROD_W'(y);
    return prod[pbtc_pkg::PROB_W+15:16];
  endfunction

  function automatic void clear_model_bins();
    for (int h = 0; h <= MAX_THR; h++) model_bins[h] = '0;
    model_bins[0] = pbtc_pkg::ONE_Q16;
  endfunction

  function automatic void accumulate_event(input pbtc_pkg::in_item_t item);
    logic [pbtc_pkg::PROB_W-1:0] a, b, p, q;
    logic [pbtc_pkg::PROB_W-1:0] prior [0:MAX_THR];
    logic [63:0]                 sum;
    int                          t;
    int                          h;
    pbtc_pkg::out_item_t         bin;
    a = clamp_prob(64'(item.prob_a));
    b = clamp_prob(64'(item.prob_b));
    sum = 64'(a);
    sum = sum + 64'(b) - 64'(q16_mul(a, b));
    p = clamp_prob(sum);
    t = int'(model_threshold);
    if (t == 0) t = 1;
    if (t > MAX_THR) t = MAX_THR;
    if (p != '0) begin
      q = pbtc_pkg::ONE_Q16 - p;
      prior = model_bins;
      sum = 64'(prior[t]);
      sum = sum + 64'(q16_mul(p, prior[t-1]));
      model_bins[t] = clamp_prob(sum);
      for (h = t - 1; h >= 1; h--) begin
        sum = 64'(q16_mul(p, prior[h-1]));
        sum = sum + 64'(q16_mul(q, prior[h]));
        model_bins[h] = clamp_prob(sum);
      end
      model_bins[0] = q16_mul(q, prior[0]);
    end
    if (item.last) begin
      for (h = 0; h <= t; h++) begin
        bin.bucket      = h[pbtc_pkg::BKT_W-1:0];
        bin.probability = model_bins[h];
        bin.final_res   = (h == t);
        expected_bins.push_back(bin);
      end
      clear_model_bins();
    end
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic pbtc_pkg::in_item_t make_item(
    input logic [pbtc_pkg::PROB_W-1:0] a,
    input logic [pbtc_pkg::PROB_W-1:0] b,
    input logic last);
    pbtc_pkg::in_item_t item;
    item.prob_a = a;
    item.prob_b = b;
    item.last   = last;
    return item;
  endfunction

  function automatic logic [pbtc_pkg::PROB_W-1:0] pick_prob();
    logic [pbtc_pkg::PROB_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = pbtc_pkg::ONE_Q16;
      2:       v = pbtc_pkg::PROB_W'($urandom);
      3:       v = pbtc_pkg::PROB_W'($urandom_range(1, 255));
      4:       v = pbtc_pkg::ONE_Q16 - pbtc_pkg::PROB_W'($urandom_range(1, 255));
      default: v = pbtc_pkg::PROB_W'($urandom_range(65536));
    endcase
    return v;
  endfunction

  function automatic logic [pbtc_pkg::BKT_W-1:0] pick_threshold();
    logic [pbtc_pkg::BKT_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = 6'd1;
      2:       v = 6'd32;
      3:       v = pbtc_pkg::BKT_W'($urandom_range(33, 63));
      default: v = pbtc_pkg::BKT_W'($urandom_range(2, 31));
    endcase
    return v;
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  task automatic send_item(input pbtc_pkg::in_item_t item);
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    accumulate_event(item);
  endtask

  // block idle: no transfer pending, all results in, pipeline flushed
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bins.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [pbtc_pkg::BKT_W-1:0] value);
    settle();
    cfg_we          = 1'b1;
    cfg_wdata       = value;
    model_threshold = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------
  always @(negedge clk)
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        note_failure($sformatf("unexpected result: bucket %0d prob %0d final %0b",
                               out_data.bucket, out_data.probability,
                               out_data.final_res));
      end else begin
        next_bin = expected_bins.pop_front();
        if (out_data.bucket !== next_bin.bucket ||
            out_data.probability !== next_bin.probability ||
            out_data.final_res !== next_bin.final_res)
          note_failure($sformatf(
            "mismatch: exp bucket %0d prob %0d final %0b, got bucket %0d prob %0d final %0b",
            next_bin.bucket, next_bin.probability, next_bin.final_res,
            out_data.bucket, out_data.probability, out_data.final_res));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_probability_extremes();
    send_item(make_item('0, '0, 1'b1));
    send_item(make_item(pbtc_pkg::ONE_Q16, '0, 1'b0));
    send_item(make_item('0, pbtc_pkg::ONE_Q16, 1'b0));
    send_item(make_item(17'h1ffff, '0, 1'b0));
    send_item(make_item('0, 17'h1ffff, 1'b0));
    send_item(make_item(17'h1ffff, 17'h1ffff, 1'b0));
    send_item(make_item(17'd32768, 17'd32768, 1'b0));
    send_item(make_item(17'd1, 17'd1, 1'b0));
    send_item(make_item('0, '0, 1'b0));
    send_item(make_item(17'd40000, 17'd12345, 1'b1));
  endtask

  task automatic test_threshold_range();
    write_threshold(6'd0);
    send_item(make_item(pbtc_pkg::ONE_Q16, '0, 1'b0));
    send_item(make_item(17'd30000, '0, 1'b1));
    write_threshold(6'd63);
    send_item(make_item(17'd50000, 17'd20000, 1'b0));
    send_item(make_item(17'd65535, '0, 1'b1));
    write_threshold(6'd1);
    send_item(make_item(17'd100, '0, 1'b1));
    write_threshold(6'd32);
    send_item(make_item(pbtc_pkg::ONE_Q16, '0, 1'b1));
  endtask

  task automatic test_threshold_midrun();
    write_threshold(6'd4);
    repeat (3) send_item(make_item(pbtc_pkg::ONE_Q16, '0, 1'b0));
    write_threshold(6'd2);
    send_item(make_item(17'd1000, 17'd2000, 1'b1));
    send_item(make_item('0, '0, 1'b1));
    write_threshold(6'd4);
    send_item(make_item('0, '0, 1'b1));
  endtask

  task automatic test_random_vectors(input int send_pct, input int recv_pct);
    int                 sent;
    int                 len;
    pbtc_pkg::in_item_t item;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < RUN_ITEMS) begin
      if ($urandom_range(1) == 0) write_threshold(pick_threshold());
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(9) == 0) write_threshold(pick_threshold());
        item.prob_a = pick_prob();
        item.prob_b = ($urandom_range(1) == 0) ? '0 : pick_prob();
        item.last   = (i == len - 1);
        send_item(item);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    model_threshold = pbtc_pkg::THRESHOLD_RST;
    clear_model_bins();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_probability_extremes();
    test_threshold_range();
    test_threshold_midrun();
    test_random_vectors(0, 0);
    test_random_vectors(82, 0);
    test_random_vectors(0, 82);
    test_random_vectors(16, 16);

    settle();
    repeat (10) @(negedge clk);
    if (expected_bins.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_bins.size()));
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
